@@ design/cfp_pkg.sv @@
`timescale 1ns / 1ps

package cfp_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam int PERIOD_W = 16;
    localparam int REPEAT_W = 16;
    localparam int SEED_W   = 18;
    localparam int LEVEL_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // period * level, kept unscaled so the duty compare needs no divide by 15
    localparam int DUTY_W = PERIOD_W + LEVEL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;
    localparam logic [REPEAT_W-1:0] REPEAT_RESET = 16'd30000;

    localparam longint unsigned LCG_MUL = 64'd8121;
    localparam longint unsigned LCG_ADD = 64'd28411;
    localparam longint unsigned LCG_MOD = 64'd134456;
    localparam logic [SEED_W:0]   LCG_MOD_1 = 19'd134456;
    localparam logic [SEED_W:0]   LCG_MOD_2 = 19'd268912;
    localparam logic [SEED_W-1:0] RAND_MOD_1 = 18'd65535;
    localparam logic [SEED_W-1:0] RAND_MOD_2 = 18'd131070;

    localparam int NUM_THRESH = 15;
    localparam int CHUNK_W    = 6;
    localparam int CHUNK_N    = 64;

    typedef logic [SEED_W-1:0]  lcg_tab_t [CHUNK_N];
    typedef logic [15:0]        thresh_t  [NUM_THRESH];

    localparam thresh_t THRESH = '{
        16'd131,   16'd262,   16'd393,   16'd524,   16'd655,
        16'd3867,  16'd7078,  16'd10289, 16'd13500, 16'd16711,
        16'd19923, 16'd23134, 16'd26345, 16'd29556, 16'd32768
    };

    typedef struct packed {
        logic               led_on;
        logic [LEVEL_W-1:0] level;
    } tick_result_t;

    // (c << sh) * mul + add, reduced mod the LCG modulus, for every 6-bit chunk c
    function automatic lcg_tab_t lcg_tab(input int sh, input longint unsigned add);
        lcg_tab_t         t;
        longint unsigned  p;
        int               c;
        for (c = 0; c < CHUNK_N; c++)
        begin
            p = (((longint'(c)) << sh) * LCG_MUL + add) % LCG_MOD;
            t[c] = p[SEED_W-1:0];
        end
        return t;
    endfunction

    localparam lcg_tab_t LCG_TAB_LO  = lcg_tab(0, LCG_ADD);
    localparam lcg_tab_t LCG_TAB_MID = lcg_tab(CHUNK_W, 64'd0);
    localparam lcg_tab_t LCG_TAB_HI  = lcg_tab(2 * CHUNK_W, 64'd0);

    // one LCG step: three chunk tables, sum below three moduli, fold back
    function automatic logic [SEED_W-1:0] lcg_step(input logic [SEED_W-1:0] x);
        logic [SEED_W:0] s;
        logic [SEED_W:0] r;
        s = {1'b0, LCG_TAB_LO[x[CHUNK_W-1:0]]}
          + {1'b0, LCG_TAB_MID[x[2*CHUNK_W-1:CHUNK_W]]}
          + {1'b0, LCG_TAB_HI[x[3*CHUNK_W-1:2*CHUNK_W]]};
        if (s >= LCG_MOD_2)
        begin
            r = s - LCG_MOD_2;
        end
        else if (s >= LCG_MOD_1)
        begin
            r = s - LCG_MOD_1;
        end
        else
        begin
            r = s;
        end
        return r[SEED_W-1:0];
    endfunction

endpackage

@@ design/cfp_lcg.sv @@
`timescale 1ns / 1ps

module cfp_lcg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          draw,
    input  logic                          seed_load,
    input  logic [cfp_pkg::SEED_W-1:0]    seed_value,
    output logic [cfp_pkg::LEVEL_W-1:0]   next_level
);

    // holds the LCG value that the next draw will use (one step ahead)
    logic [cfp_pkg::SEED_W-1:0] lcg_next_reg;
    logic [cfp_pkg::SEED_W-1:0] lcg_next_next;
    logic [cfp_pkg::SEED_W-1:0] rand_val;
    logic [cfp_pkg::NUM_THRESH-1:0] below;
    logic [cfp_pkg::LEVEL_W-1:0] pick;

    always_comb
    begin
        if (seed_load)
        begin
            lcg_next_next = cfp_pkg::lcg_step(seed_value);
        end
        else if (draw)
        begin
            lcg_next_next = cfp_pkg::lcg_step(lcg_next_reg);
        end
        else
        begin
            lcg_next_next = lcg_next_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_next_reg <= cfp_pkg::lcg_step('0);
        end
        else
        begin
            lcg_next_reg <= lcg_next_next;
        end
    end

    // value mod 65535; the LCG value stays below three times that
    always_comb
    begin
        if (lcg_next_reg >= cfp_pkg::RAND_MOD_2)
        begin
            rand_val = lcg_next_reg - cfp_pkg::RAND_MOD_2;
        end
        else if (lcg_next_reg >= cfp_pkg::RAND_MOD_1)
        begin
            rand_val = lcg_next_reg - cfp_pkg::RAND_MOD_1;
        end
        else
        begin
            rand_val = lcg_next_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < cfp_pkg::NUM_THRESH; i++)
        begin
            below[i] = rand_val < {2'b00, cfp_pkg::THRESH[i]};
        end
    end

    // first threshold above the value, else top level
    always_comb
    begin
        pick = cfp_pkg::LEVEL_W'(cfp_pkg::NUM_THRESH);
        for (int i = cfp_pkg::NUM_THRESH - 1; i >= 0; i--)
        begin
            if (below[i])
            begin
                pick = cfp_pkg::LEVEL_W'(i);
            end
        end
    end

    assign next_level = pick;

endmodule

@@ design/cfp_pwm.sv @@
`timescale 1ns / 1ps

module cfp_pwm
#(
    parameter int COUNT_WIDTH = cfp_pkg::COUNT_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick_en,
    input  logic                           advance,
    input  logic [cfp_pkg::PERIOD_W-1:0]   period,
    input  logic [cfp_pkg::REPEAT_W-1:0]   repeat_cnt,
    input  logic [cfp_pkg::LEVEL_W-1:0]    next_level,
    output logic                           draw,
    output cfp_pkg::tick_result_t          result
);

    localparam int CMP_W = (COUNT_WIDTH + 5 > cfp_pkg::DUTY_W) ? COUNT_WIDTH + 5
                                                               : cfp_pkg::DUTY_W;
    localparam int WRAP_W = (COUNT_WIDTH > cfp_pkg::PERIOD_W) ? COUNT_WIDTH
                                                              : cfp_pkg::PERIOD_W;

    logic [COUNT_WIDTH-1:0]       phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]       burst_reg, burst_next;
    logic [COUNT_WIDTH-1:0]       burst_cur;
    logic [cfp_pkg::LEVEL_W-1:0]  level_reg, level_next;
    logic [cfp_pkg::DUTY_W-1:0]   duty_reg, duty_next;
    logic                         draw_cond;
    logic                         step;
    logic [COUNT_WIDTH-1:0]       phase_inc;
    logic [CMP_W-1:0]             phase_one;
    logic [CMP_W-1:0]             phase_x15;

    assign draw_cond = advance && (burst_reg == '0) && (phase_reg == '0);
    assign draw      = tick_en && draw_cond;
    assign step      = tick_en && advance;

    always_comb
    begin
        if (draw_cond)
        begin
            level_next = next_level;
            duty_next  = cfp_pkg::DUTY_W'(period) * cfp_pkg::DUTY_W'(next_level);
            burst_cur  = COUNT_WIDTH'(repeat_cnt);
        end
        else
        begin
            level_next = level_reg;
            duty_next  = duty_reg;
            burst_cur  = burst_reg;
        end
    end

    // phase < period*level/15  <=>  15*(phase+1) <= period*level
    assign phase_one = CMP_W'(phase_reg) + CMP_W'(1);
    assign phase_x15 = (phase_one << 4) - phase_one;

    assign result.led_on = phase_x15 <= CMP_W'(duty_next);
    assign result.level  = level_next;

    assign phase_inc = phase_reg + COUNT_WIDTH'(1);

    always_comb
    begin
        burst_next = burst_cur;
        if (WRAP_W'(phase_inc) >= WRAP_W'(period))
        begin
            phase_next = '0;
            if (burst_cur != '0)
            begin
                burst_next = burst_cur - COUNT_WIDTH'(1);
            end
        end
        else
        begin
            phase_next = phase_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            burst_reg <= '0;
            level_reg <= '0;
            duty_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            burst_reg <= burst_next;
            level_reg <= level_next;
            duty_reg  <= duty_next;
        end
    end

endmodule

@@ design/candle_flicker_pwm.sv @@
`timescale 1ns / 1ps

// Candle-flicker LED driver. Each request is one time tick; a request with
// advance low reports the present LED level and brightness and changes nothing.
// The block takes one request per clock while in_stall is low and registers its
// result, so a stall on the result side backs up into in_stall only while that
// register is full. A draw of a new brightness level is one LCG step done
// through three constant chunk tables, kept one step ahead of use so the tick
// that draws already shows the new level. The duty compare works on
// period*level so no divider is needed. Configuration (period, repeat count,
// seed) is written through cfg_wr_en, cfg_index and cfg_data, by the user only
// while no request is in flight (unchecked); writing the seed restarts the LCG.
module candle_flicker_pwm
#(
    parameter int COUNT_WIDTH = cfp_pkg::COUNT_WIDTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              advance,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              led_on,
    output logic [cfp_pkg::LEVEL_W-1:0]       level,
    input  logic                              cfg_wr_en,
    input  logic [cfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cfp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [cfp_pkg::PERIOD_W-1:0] period_reg;
    logic [cfp_pkg::REPEAT_W-1:0] repeat_reg;
    logic                         seed_load;
    logic                         accept;
    logic                         draw;
    logic [cfp_pkg::LEVEL_W-1:0]  next_level;
    cfp_pkg::tick_result_t        tick_res;
    logic                         out_valid_reg;
    cfp_pkg::tick_result_t        out_res_reg;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign seed_load = cfg_wr_en && (cfg_index == cfp_pkg::CFG_SEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= cfp_pkg::PERIOD_RESET;
            repeat_reg <= cfp_pkg::REPEAT_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == cfp_pkg::CFG_PERIOD)
            begin
                period_reg <= cfg_data[cfp_pkg::PERIOD_W-1:0];
            end
            if (cfg_index == cfp_pkg::CFG_REPEAT)
            begin
                repeat_reg <= cfg_data[cfp_pkg::REPEAT_W-1:0];
            end
        end
    end

    cfp_lcg u_lcg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .draw       (draw),
        .seed_load  (seed_load),
        .seed_value (cfg_data[cfp_pkg::SEED_W-1:0]),
        .next_level (next_level)
    );

    cfp_pwm
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_pwm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (accept),
        .advance    (advance),
        .period     (period_reg),
        .repeat_cnt (repeat_reg),
        .next_level (next_level),
        .draw       (draw),
        .result     (tick_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_res_reg <= tick_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_on    = out_res_reg.led_on;
    assign level     = out_res_reg.level;

endmodule

@@ dv/cfp_checker.sv @@
`timescale 1ns / 1ps

module cfp_checker
#(
    parameter int COUNT_WIDTH = cfp_pkg::COUNT_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           advance,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           led_on,
    input  logic [cfp_pkg::LEVEL_W-1:0]    level,
    input  logic                           cfg_wr_en,
    input  logic [cfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             outstanding,
    output int                             checked,
    output logic [15:0]                    levels_seen
);

    logic [cfp_pkg::PERIOD_W-1:0] period_cfg;
    logic [cfp_pkg::REPEAT_W-1:0] repeat_cfg;
    logic [cfp_pkg::SEED_W-1:0]   lcg_state;
    logic [cfp_pkg::LEVEL_W-1:0]  bright;
    logic [cfp_pkg::PERIOD_W-1:0] duty;
    logic [COUNT_WIDTH-1:0]       phase;
    logic [COUNT_WIDTH-1:0]       burst;

    cfp_pkg::tick_result_t tick_q[$];
    cfp_pkg::tick_result_t predicted;
    cfp_pkg::tick_result_t wanted;

    function automatic int unsigned flicker_bound(input int idx);
        case (idx)
            0:       return 131;
            1:       return 262;
            2:       return 393;
            3:       return 524;
            4:       return 655;
            5:       return 3867;
            6:       return 7078;
            7:       return 10289;
            8:       return 13500;
            9:       return 16711;
            10:      return 19923;
            11:      return 23134;
            12:      return 26345;
            13:      return 29556;
            default: return 32768;
        endcase
    endfunction

    // one tick of the flicker driver; a draw happens on an advancing tick at burst and phase both zero
    task automatic predict_tick(input logic adv, output cfp_pkg::tick_result_t res);
        logic [COUNT_WIDTH-1:0] nx;
        longint unsigned        rnd;
        int unsigned            v;
        int unsigned            lvl;
        int unsigned            prod;
        int                     i;
        begin
            if (adv && burst == '0 && phase == '0)
            begin
                rnd = (64'(lcg_state) * cfp_pkg::LCG_MUL + cfp_pkg::LCG_ADD)
                      % cfp_pkg::LCG_MOD;
                lcg_state = rnd[cfp_pkg::SEED_W-1:0];
                v = 32'(rnd % 64'd65535);
                lvl = 15;
                for (i = 14; i >= 0; i--)
                begin
                    if (v < flicker_bound(i))
                        lvl = i;
                end
                bright = lvl[cfp_pkg::LEVEL_W-1:0];
                prod = 32'(period_cfg) * lvl;
                prod = prod / 15;
                duty = prod[cfp_pkg::PERIOD_W-1:0];
                burst = COUNT_WIDTH'(repeat_cfg);
            end
            res.led_on = (phase < duty);
            res.level  = bright;
            if (adv)
            begin
                nx = phase + COUNT_WIDTH'(1);
                if (nx >= period_cfg)
                begin
                    phase = '0;
                    if (burst != '0)
                        burst = burst - COUNT_WIDTH'(1);
                end
                else
                begin
                    phase = nx;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_cfg  = cfp_pkg::PERIOD_RESET;
            repeat_cfg  = cfp_pkg::REPEAT_RESET;
            lcg_state   = '0;
            bright      = '0;
            duty        = '0;
            phase       = '0;
            burst       = '0;
            tick_q.delete();
            fail_count  = 0;
            outstanding = 0;
            checked     = 0;
            levels_seen = '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    cfp_pkg::CFG_PERIOD: period_cfg = cfg_data[cfp_pkg::PERIOD_W-1:0];
                    cfp_pkg::CFG_REPEAT: repeat_cfg = cfg_data[cfp_pkg::REPEAT_W-1:0];
                    cfp_pkg::CFG_SEED:   lcg_state  = cfg_data[cfp_pkg::SEED_W-1:0];
                    default:             ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_tick(advance, predicted);
                tick_q.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (tick_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no request outstanding: led_on %0b level %0d",
                             $time, led_on, level);
                end
                else
                begin
                    wanted = tick_q.pop_front();
                    checked++;
                    levels_seen[level] = 1'b1;
                    if (led_on !== wanted.led_on)
                    begin
                        fail_count++;
                        $display("%0t: led_on mismatch: expected %0b, actual %0b",
                                 $time, wanted.led_on, led_on);
                    end
                    if (level !== wanted.level)
                    begin
                        fail_count++;
                        $display("%0t: level mismatch: expected %0d, actual %0d",
                                 $time, wanted.level, level);
                    end
                end
            end
            outstanding = tick_q.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam logic [cfp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic                           advance;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           led_on;
    logic [cfp_pkg::LEVEL_W-1:0]    level;
    logic                           cfg_wr_en;
    logic [cfp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cfp_pkg::CFG_DATA_W-1:0] cfg_data;

    int          fail_count;
    int          outstanding;
    int          checked;
    logic [15:0] levels_seen;

    int gap_pct   = 0;
    int stall_pct = 0;
    int n_sent    = 0;
    int n_held    = 0;

    candle_flicker_pwm dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .led_on    (led_on),
        .level     (level),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfp_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .led_on      (led_on),
        .level       (level),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked),
        .levels_seen (levels_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still outstanding", outstanding);
        $display("Test completed with failures");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_tick(input logic adv);
        begin
            while ($urandom_range(99) < gap_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            advance  <= adv;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            n_sent++;
            if (!adv)
                n_held++;
            @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            while (outstanding != 0)
                @(negedge clk);
            repeat (2) @(negedge clk);
        end
    endtask

    task automatic cfg_write(input logic [cfp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cfp_pkg::CFG_DATA_W-1:0] d);
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= d;
            @(negedge clk);
            cfg_wr_en <= 1'b0;
            @(negedge clk);
        end
    endtask

    initial
    begin
        int unsigned                    pick;
        logic [cfp_pkg::PERIOD_W-1:0]   per;
        logic [cfp_pkg::REPEAT_W-1:0]   rep;
        logic [cfp_pkg::SEED_W-1:0]     sd;
        logic [cfp_pkg::CFG_DATA_W-1:0] d;
        int                             seg;
        int                             k;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        advance   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = cfp_pkg::CFG_PERIOD;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // held ticks before the first draw
        send_tick(1'b0);
        send_tick(1'b0);
        wait_idle();

        // first draw at reset period, short burst
        cfg_write(cfp_pkg::CFG_REPEAT, 18'd1);
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();

        // shrink period mid-burst, seed above the LCG range
        cfg_write(cfp_pkg::CFG_PERIOD, 18'd2);
        cfg_write(cfp_pkg::CFG_SEED, 18'h3FFFF);
        repeat (4) send_tick(1'b1);
        wait_idle();

        // zero period and zero repeat: draw every tick once the burst left over runs out
        cfg_write(cfp_pkg::CFG_PERIOD, 18'd0);
        cfg_write(cfp_pkg::CFG_REPEAT, 18'd0);
        repeat (4) send_tick(1'b1);
        wait_idle();

        cfg_write(cfp_pkg::CFG_PERIOD, 18'd1);
        cfg_write(cfp_pkg::CFG_SEED, 18'd134455);
        repeat (3) send_tick(1'b1);
        wait_idle();

        cfg_write(cfp_pkg::CFG_PERIOD, 18'd65535);
        cfg_write(cfp_pkg::CFG_SEED, 18'd0);
        cfg_write(CFG_SPARE, '1);
        repeat (3) send_tick(1'b1);
        wait_idle();

        // duty left over from the long period exceeds the new one
        cfg_write(cfp_pkg::CFG_PERIOD, 18'd15);
        cfg_write(cfp_pkg::CFG_REPEAT, 18'd2);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_idle();

        for (seg = 0; seg < 8; seg++)
        begin
            case (seg % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 55;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 55;
                end
                default:
                begin
                    gap_pct   = 20;
                    stall_pct = 20;
                end
            endcase

            pick = $urandom_range(99);
            if (pick < 70)
                per = cfp_pkg::PERIOD_W'($urandom_range(1, 12));
            else if (pick < 85)
                per = cfp_pkg::PERIOD_W'($urandom_range(13, 200));
            else if (pick < 93)
                per = '0;
            else
                per = cfp_pkg::PERIOD_W'($urandom_range(1000, 65535));
            d = {2'($urandom_range(3)), per};
            cfg_write(cfp_pkg::CFG_PERIOD, d);

            if (seg == 7)
                rep = 16'hFFFF;
            else if ($urandom_range(3) == 0)
                rep = cfp_pkg::REPEAT_W'($urandom_range(5, 20));
            else
                rep = cfp_pkg::REPEAT_W'($urandom_range(0, 4));
            d = {2'($urandom_range(3)), rep};
            cfg_write(cfp_pkg::CFG_REPEAT, d);

            if ($urandom_range(1) == 1)
            begin
                if ($urandom_range(9) == 0)
                    sd = cfp_pkg::SEED_W'($urandom_range(134456, 262143));
                else
                    sd = cfp_pkg::SEED_W'($urandom_range(0, 134455));
                cfg_write(cfp_pkg::CFG_SEED, sd);
            end

            for (k = 0; k < 94; k++)
                send_tick($urandom_range(99) < 85);
            wait_idle();
        end

        repeat (5) @(posedge clk);
        $display("Ran %0d tick requests (%0d held) over 4 idle/stall mixes, %0d results checked",
                 n_sent, n_held, checked);
        $display("Brightness levels observed (bit per level): %016b", levels_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
